[rtl/tast_pkg.sv]
// Shared types and constants for the two-axis servo trajectory generator.
`timescale 1ns / 1ps

package tast_pkg;

  // Command codes carried with each request.
  typedef enum logic [2:0] {
    CMD_MOVE    = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_SET     = 3'd2,
    CMD_CENTER  = 3'd3,
    CMD_CAPTURE = 3'd4
  } cmd_t;

  // Meaning of move_value.
  localparam logic MODE_SPEED    = 1'b0;
  localparam logic MODE_DURATION = 1'b1;

  localparam int VALUE_BITS   = 16;
  localparam int CENTER_RESET = 1500;

  // Handshake between the port logic and the sequencer.
  typedef struct packed {
    logic start;   // a request is accepted this cycle
    logic taken;   // the finished result moves into the output register
  } seq_ctrl_t;

  typedef struct packed {
    logic idle;          // sequencer can take a request
    logic result_ready;  // position and arrival flag are final
  } seq_stat_t;

endpackage

[rtl/tast_alu.sv]
// Shared adder/subtractor used for the compare, multiply, divide and apply steps of the sequencer.
`timescale 1ns / 1ps

module tast_alu #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic         carry
);

  // With sub set, carry high means a >= b (no borrow).
  assign {carry, res} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};

endmodule

[rtl/tast_seq.sv]
// Trajectory state and the sequencer that drives the shared arithmetic unit.
`timescale 1ns / 1ps

module tast_seq
  import tast_pkg::*;
#(
  parameter int PULSE_BITS = 12,
  parameter int TIME_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  seq_ctrl_t             ctrl,
  input  logic [2:0]            command,
  input  logic [PULSE_BITS-1:0] target_x,
  input  logic [PULSE_BITS-1:0] target_y,
  input  logic                  move_mode,
  input  logic [VALUE_BITS-1:0] move_value,
  input  logic [TIME_BITS-1:0]  elapsed,
  output seq_stat_t             stat,
  output logic [PULSE_BITS-1:0] pos_x,
  output logic [PULSE_BITS-1:0] pos_y,
  output logic                  arrived
);

  localparam int P        = PULSE_BITS;
  localparam int DUR_BITS = PULSE_BITS + VALUE_BITS;
  localparam int AW       = ((TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS) + 1;
  localparam int CW       = $clog2(PULSE_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_SPEED_MUL, S_CMP, S_MUL, S_DIV, S_APPLY, S_FINISH
  } state_t;

  state_t              state;
  logic [P-1:0]        start_x, start_y, goal_x, goal_y, now_x, now_y;
  logic [P-1:0]        center_x, center_y;
  logic [DUR_BITS-1:0] move_duration;
  logic                axis;
  logic [AW-1:0]       hi;
  logic [P-1:0]        lo;
  logic [CW-1:0]       cnt;
  logic [TIME_BITS-1:0]  elapsed_r;
  logic [VALUE_BITS-1:0] value_r;

  logic [P-1:0]  sel_x, sel_y, dist_x, dist_y, dist_max;
  logic [P-1:0]  s_axis, g_axis, d_axis;
  logic [AW-1:0] mcand, shifted;
  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic          alu_sub, alu_carry;
  logic [AW-1:0] hi_next;
  logic [P-1:0]  lo_next;
  logic          last_step;

  function automatic logic [PULSE_BITS-1:0] absdiff(input logic [PULSE_BITS-1:0] a,
                                                     input logic [PULSE_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    sel_x  = (cmd_t'(command) == CMD_CENTER) ? center_x : target_x;
    sel_y  = (cmd_t'(command) == CMD_CENTER) ? center_y : target_y;
    dist_x = absdiff(now_x, sel_x);
    dist_y = absdiff(now_y, sel_y);
    dist_max = (dist_x > dist_y) ? dist_x : dist_y;
    s_axis = axis ? start_y : start_x;
    g_axis = axis ? goal_y : goal_x;
    d_axis = absdiff(s_axis, g_axis);
    mcand  = (state == S_SPEED_MUL) ? AW'(value_r) : AW'(elapsed_r);
    shifted = {hi[AW-2:0], lo[P-1]};
    last_step = (cnt == CW'(P - 1));
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = hi;
    alu_b   = lo[0] ? mcand : '0;
    alu_sub = 1'b0;
    case (state)
      S_CMP: begin
        alu_a   = AW'(elapsed_r);
        alu_b   = AW'(move_duration);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = shifted;
        alu_b   = AW'(move_duration);
        alu_sub = 1'b1;
      end
      S_APPLY: begin
        alu_a   = AW'(s_axis);
        alu_b   = AW'(lo);
        alu_sub = (g_axis < s_axis);
      end
      default: begin
        alu_a   = hi;
        alu_b   = lo[0] ? mcand : '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  tast_alu #(.W(AW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  // Shift-add multiply step: add, then shift the whole product right by one.
  always_comb begin
    hi_next = {alu_carry, alu_res[AW-1:1]};
    lo_next = {alu_res[0], lo[P-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      start_x       <= '0;
      start_y       <= '0;
      goal_x        <= '0;
      goal_y        <= '0;
      now_x         <= '0;
      now_y         <= '0;
      center_x      <= P'(CENTER_RESET);
      center_y      <= P'(CENTER_RESET);
      move_duration <= '0;
      axis          <= 1'b0;
      cnt           <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            elapsed_r <= elapsed;
            value_r   <= move_value;
            case (cmd_t'(command))
              CMD_MOVE, CMD_CENTER: begin
                goal_x <= sel_x;
                goal_y <= sel_y;
                if (move_value == '0) begin
                  now_x         <= sel_x;
                  now_y         <= sel_y;
                  start_x       <= sel_x;
                  start_y       <= sel_y;
                  move_duration <= '0;
                  state         <= S_FINISH;
                end else begin
                  start_x <= now_x;
                  start_y <= now_y;
                  if (move_mode == MODE_DURATION) begin
                    move_duration <= DUR_BITS'(move_value);
                    state         <= S_FINISH;
                  end else begin
                    hi    <= '0;
                    lo    <= dist_max;
                    cnt   <= '0;
                    state <= S_SPEED_MUL;
                  end
                end
              end
              CMD_TICK: begin
                if (move_duration == '0) begin
                  now_x <= goal_x;
                  now_y <= goal_y;
                  state <= S_FINISH;
                end else begin
                  axis  <= 1'b0;
                  state <= S_CMP;
                end
              end
              CMD_SET: begin
                now_x <= target_x;
                now_y <= target_y;
                state <= S_FINISH;
              end
              CMD_CAPTURE: begin
                center_x <= now_x;
                center_y <= now_y;
                state    <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SPEED_MUL: begin
          hi  <= hi_next;
          lo  <= lo_next;
          cnt <= cnt + 1'b1;
          if (last_step) begin
            move_duration <= DUR_BITS'({hi_next, lo_next});
            state         <= S_FINISH;
          end
        end
        S_CMP: begin
          // Elapsed at or past the duration lands exactly on the goal.
          lo <= d_axis;
          if (alu_carry) begin
            state <= S_APPLY;
          end else begin
            hi    <= '0;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hi <= hi_next;
          lo <= lo_next;
          if (last_step) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          // The quotient fits in PULSE_BITS, so only that many steps run.
          if (alu_carry) begin
            hi <= alu_res;
            lo <= {lo[P-2:0], 1'b1};
          end else begin
            hi <= shifted;
            lo <= {lo[P-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!axis) begin
            now_x <= alu_res[P-1:0];
            axis  <= 1'b1;
            state <= S_CMP;
          end else begin
            now_y <= alu_res[P-1:0];
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (ctrl.taken) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle         = (state == S_IDLE);
  assign stat.result_ready = (state == S_FINISH);
  assign pos_x   = now_x;
  assign pos_y   = now_y;
  assign arrived = (now_x == goal_x) && (now_y == goal_y);

endmodule

[rtl/two_axis_servo_trajectory.sv]
// Top level of the two-axis servo trajectory generator: ports, output register, checks.
`timescale 1ns / 1ps
//
//  Channel   Direction  Carries
//  s_axis    in         one command request: target, move mode and value, elapsed time
//  m_axis    out        one result per request: position of both axes and arrival flag
//
//  A tick request whose elapsed time is below the move duration runs, for each axis, a
//  PULSE_BITS-step shift-add multiply and a PULSE_BITS-step restoring divide through one
//  shared adder. A tick past the duration applies the goal to each axis directly, and a
//  speed-mode move runs one PULSE_BITS-step multiply; other requests finish directly.
//  Reset is synchronous and active high; the position and goal return to zero and the
//  stored center to 1500. The finished result waits in the output register while the
//  next request is taken; a result only stalls the sequencer when that register is full.

module two_axis_servo_trajectory
  import tast_pkg::*;
#(
  parameter int PULSE_BITS = 12,
  parameter int TIME_BITS  = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0 up: target_x, target_y, move_value, elapsed, zero padding.
  input  logic [((2*PULSE_BITS+VALUE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Fields from bit 0 up: command (3 bits), move_mode (1 bit).
  input  logic [3:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Fields from bit 0 up: pos_x, pos_y, arrived, zero padding.
  output logic [((2*PULSE_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

  localparam int P     = PULSE_BITS;
  localparam int OUT_W = ((2*PULSE_BITS+1+7)/8)*8;
  localparam int PAD_W = OUT_W - (2*P + 1);

  seq_ctrl_t ctrl;
  seq_stat_t stat;
  logic [P-1:0] pos_x, pos_y, pos_x_r, pos_y_r;
  logic         arrived, arrived_r;
  logic         out_free;

  // The output register is free when empty or being drained this cycle.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = stat.idle;
  assign ctrl.start    = s_axis_tvalid && stat.idle;
  assign ctrl.taken    = stat.result_ready && out_free;

  tast_seq #(
    .PULSE_BITS (PULSE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .command    (s_axis_tuser[2:0]),
    .target_x   (s_axis_tdata[P-1:0]),
    .target_y   (s_axis_tdata[2*P-1:P]),
    .move_mode  (s_axis_tuser[3]),
    .move_value (s_axis_tdata[2*P+VALUE_BITS-1:2*P]),
    .elapsed    (s_axis_tdata[2*P+VALUE_BITS+TIME_BITS-1:2*P+VALUE_BITS]),
    .stat       (stat),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .arrived    (arrived)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ctrl.taken) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (ctrl.taken) begin
      pos_x_r   <= pos_x;
      pos_y_r   <= pos_y;
      arrived_r <= arrived;
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, arrived_r, pos_y_r, pos_x_r};

  // An accepted request always makes the sequencer busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer still idle after accepting a request");

  // A result handed over always shows up on the output channel.
  a_result_delivered: assert property (@(posedge clk) disable iff (rst)
    ctrl.taken |=> m_axis_tvalid)
    else $error("finished result not loaded into the output register");

  // A finished result held back by a full output register is not dropped.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (stat.result_ready && !out_free) |=> stat.result_ready)
    else $error("finished result lost while the output register was full");

endmodule

[dv/tb_two_axis_servo_trajectory.sv]
// Self-checking testbench for the two-axis servo trajectory generator.
`timescale 1ns / 1ps

module tb_two_axis_servo_trajectory;
  import tast_pkg::*;

  localparam int PULSE_BITS = 12;
  localparam int TIME_BITS  = 24;
  localparam int ITEMS      = 1350;
  localparam int QUIET_TAIL = 150;       // final requests sent with no idling on either side
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;     // settle time after the last request; a tick is the longest request
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [TIME_BITS-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic [PULSE_BITS-1:0] x;
    logic [PULSE_BITS-1:0] y;
    logic                  arrived;
  } servo_pos_t;

  // One directed request; when pin is set the result is the literal in want.
  typedef struct packed {
    logic [2:0]            cmd;
    logic [PULSE_BITS-1:0] tx;
    logic [PULSE_BITS-1:0] ty;
    logic                  mode;
    logic [15:0]           val;
    logic [TIME_BITS-1:0]  el;
    logic                  pin;
    servo_pos_t            want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  two_axis_servo_trajectory #(
    .PULSE_BITS(PULSE_BITS),
    .TIME_BITS (TIME_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the trajectory state, updated as each request is accepted.
  logic [PULSE_BITS-1:0] from_x, from_y, goal_x, goal_y, at_x, at_y, home_x, home_y;
  logic [PULSE_BITS+15:0] travel_ticks;

  servo_pos_t pending_pos[$];
  servo_pos_t got_pos, want_pos;
  servo_pos_t pin_pos;
  logic       pin_en;

  int errors, n_sent, n_checked, n_ticks, n_moves;
  int stall_left;
  plan_row_t plan [25];

  function automatic logic [PULSE_BITS-1:0] lerp_axis(logic [PULSE_BITS-1:0] s,
                                                       logic [PULSE_BITS-1:0] g,
                                                       logic [TIME_BITS-1:0] el);
    logic [63:0] span, step, dur, t;
    if (travel_ticks == 0) return g;
    span = (s > g) ? 64'(s - g) : 64'(g - s);
    t    = 64'(el);
    dur  = 64'(travel_ticks);
    // Truncating division, held at the goal once time runs past the duration.
    step = (t * span) / dur;
    if (step > span) step = span;
    return (g >= s) ? PULSE_BITS'(64'(s) + step) : PULSE_BITS'(64'(s) - step);
  endfunction

  function automatic void begin_travel(logic [PULSE_BITS-1:0] tx, logic [PULSE_BITS-1:0] ty,
                                       logic mode, logic [15:0] val);
    logic [PULSE_BITS-1:0] dx, dy, dist_max;
    if (val == 0) begin
      // Immediate move: everything collapses onto the target.
      at_x = tx; at_y = ty; from_x = tx; from_y = ty; goal_x = tx; goal_y = ty;
      travel_ticks = '0;
      return;
    end
    from_x = at_x; from_y = at_y; goal_x = tx; goal_y = ty;
    if (mode == MODE_SPEED) begin
      dx = (from_x > goal_x) ? from_x - goal_x : goal_x - from_x;
      dy = (from_y > goal_y) ? from_y - goal_y : goal_y - from_y;
      dist_max = (dx > dy) ? dx : dy;
      travel_ticks = (PULSE_BITS+16)'(dist_max) * (PULSE_BITS+16)'(val);
    end else begin
      travel_ticks = (PULSE_BITS+16)'(val);
    end
  endfunction

  function automatic servo_pos_t advance_servo(logic [2:0] cmd, logic [PULSE_BITS-1:0] tx,
                                               logic [PULSE_BITS-1:0] ty, logic mode,
                                               logic [15:0] val, logic [TIME_BITS-1:0] el);
    servo_pos_t r;
    logic [PULSE_BITS-1:0] nx, ny;
    case (cmd)
      CMD_MOVE:    begin_travel(tx, ty, mode, val);
      CMD_TICK: begin
        nx = lerp_axis(from_x, goal_x, el);
        ny = lerp_axis(from_y, goal_y, el);
        at_x = nx;
        at_y = ny;
      end
      CMD_SET: begin
        at_x = tx;
        at_y = ty;
      end
      CMD_CENTER:  begin_travel(home_x, home_y, mode, val);
      CMD_CAPTURE: begin
        home_x = at_x;
        home_y = at_y;
      end
      default: ;
    endcase
    r.x = at_x;
    r.y = at_y;
    r.arrived = (at_x == goal_x) && (at_y == goal_y);
    return r;
  endfunction

  // Results are checked before the request of the same edge is predicted; the block
  // never answers a request on the edge that accepts it.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_pos.x       = m_axis_tdata[PULSE_BITS-1:0];
        got_pos.y       = m_axis_tdata[2*PULSE_BITS-1:PULSE_BITS];
        got_pos.arrived = m_axis_tdata[2*PULSE_BITS];
        if (pending_pos.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual x %0d y %0d arrived %0d",
                   $time, got_pos.x, got_pos.y, got_pos.arrived);
        end else begin
          want_pos = pending_pos.pop_front();
          n_checked++;
          if (got_pos.x !== want_pos.x) begin
            errors++;
            $display("%0t: pos_x mismatch: expected %0d actual %0d",
                     $time, want_pos.x, got_pos.x);
          end
          if (got_pos.y !== want_pos.y) begin
            errors++;
            $display("%0t: pos_y mismatch: expected %0d actual %0d",
                     $time, want_pos.y, got_pos.y);
          end
          if (got_pos.arrived !== want_pos.arrived) begin
            errors++;
            $display("%0t: arrived mismatch: expected %0d actual %0d",
                     $time, want_pos.arrived, got_pos.arrived);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want_pos = advance_servo(s_axis_tuser[2:0], s_axis_tdata[PULSE_BITS-1:0],
                                 s_axis_tdata[2*PULSE_BITS-1:PULSE_BITS], s_axis_tuser[3],
                                 s_axis_tdata[2*PULSE_BITS+15:2*PULSE_BITS],
                                 s_axis_tdata[2*PULSE_BITS+16+TIME_BITS-1:2*PULSE_BITS+16]);
        if (pin_en) want_pos = pin_pos;
        pending_pos.push_back(want_pos);
      end
    end
  end

  // Idling is allowed in bursts, with every fourth window of requests left clean,
  // and is switched off entirely for the tail of the run.
  function automatic bit idle_allowed();
    return (n_sent < ITEMS - QUIET_TAIL) && (((n_sent / 120) % 4) != 3);
  endfunction

  // Receiver side: stalls come in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (idle_allowed() && $urandom_range(0, 15) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Called at a falling edge; returns at a falling edge after acceptance and any random idling.
  task automatic issue_request(logic [2:0] cmd, logic [PULSE_BITS-1:0] tx,
                               logic [PULSE_BITS-1:0] ty, logic mode, logic [15:0] val,
                               logic [TIME_BITS-1:0] el, logic pin, servo_pos_t want);
    s_axis_tdata  = {el, val, ty, tx};
    s_axis_tuser  = {mode, cmd};
    pin_en        = pin;
    pin_pos       = want;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
    if (cmd == CMD_TICK) n_ticks++;
    if (cmd == CMD_MOVE || cmd == CMD_CENTER) n_moves++;
    @(negedge clk);
    if (idle_allowed() && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic send_random(logic [2:0] cmd, logic [PULSE_BITS-1:0] tx,
                             logic [PULSE_BITS-1:0] ty, logic mode, logic [15:0] val,
                             logic [TIME_BITS-1:0] el);
    issue_request(cmd, tx, ty, mode, val, el, 1'b0, '0);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending_pos.size() != 0) @(negedge clk);
  endtask

  // A move followed by a run of ticks whose elapsed times walk across the duration
  // and usually a little past it. Fields a command ignores carry random values.
  task automatic run_trajectory();
    logic [2:0]            cmd;
    logic                  mode;
    logic [15:0]           val;
    logic [PULSE_BITS-1:0] tx, ty;
    longint                span, el;
    int                    ticks;
    cmd  = ($urandom_range(0, 5) == 0) ? CMD_CENTER : CMD_MOVE;
    mode = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0)
      val = 16'($urandom_range(1, 65535));
    else if (mode == MODE_SPEED)
      val = 16'($urandom_range(1, 20));
    else
      val = 16'($urandom_range(1, 4000));
    tx = 12'($urandom);
    ty = 12'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      tx = at_x;
      ty = at_y;
    end
    send_random(cmd, tx, ty, mode, val, 24'($urandom));
    // The move has been predicted by now, so its duration is known here.
    span = longint'(travel_ticks) + longint'(travel_ticks) / 4 + 1;
    if (span > longint'(ELAPSED_MAX)) span = longint'(ELAPSED_MAX);
    ticks = $urandom_range(2, 8);
    for (int j = 0; j < ticks; j++) begin
      el = (span * (j + 1)) / ticks;
      if ($urandom_range(0, 3) == 0) el = longint'($urandom_range(0, int'(span)));
      send_random(CMD_TICK, 12'($urandom), 12'($urandom), 1'($urandom), 16'($urandom),
                  TIME_BITS'(el));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b1;
    pin_en  = 1'b0;
    pin_pos = '0;
    stall_left = 0;
    errors = 0; n_sent = 0; n_checked = 0; n_ticks = 0; n_moves = 0;
    from_x = '0; from_y = '0; goal_x = '0; goal_y = '0; at_x = '0; at_y = '0;
    home_x = PULSE_BITS'(CENTER_RESET);
    home_y = PULSE_BITS'(CENTER_RESET);
    travel_ticks = '0;

    plan = '{
      // A tick with no move begun lands on the reset goal.
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd0,    1'b1,
        '{12'd0,    12'd0,    1'b1}},
      // Immediate move to the reset center.
      '{CMD_CENTER,  12'd0,    12'd0,    MODE_DURATION, 16'd0,     24'd0,    1'b1,
        '{12'd1500, 12'd1500, 1'b1}},
      '{CMD_SET,     12'd4095, 12'd4095, MODE_SPEED,    16'd0,     24'd0,    1'b1,
        '{12'd4095, 12'd4095, 1'b0}},
      // Move start: position holds, start is the current position.
      '{CMD_MOVE,    12'd0,    12'd0,    MODE_DURATION, 16'd1000,  24'd0,    1'b1,
        '{12'd4095, 12'd4095, 1'b0}},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd0,    1'b0, '0},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd500,  1'b0, '0},
      // Elapsed far beyond the duration clamps to the goal.
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     ELAPSED_MAX, 1'b1,
        '{12'd0,    12'd0,    1'b1}},
      '{CMD_CAPTURE, 12'd4095, 12'd4095, MODE_DURATION, 16'hFFFF,  ELAPSED_MAX, 1'b1,
        '{12'd0,    12'd0,    1'b1}},
      '{CMD_SET,     12'd4095, 12'd0,    MODE_SPEED,    16'd0,     24'd0,    1'b1,
        '{12'd4095, 12'd0,    1'b0}},
      // Largest speed-mode duration: full distance times the largest factor.
      '{CMD_MOVE,    12'd0,    12'd4095, MODE_SPEED,    16'hFFFF,  24'd0,    1'b1,
        '{12'd4095, 12'd0,    1'b0}},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     ELAPSED_MAX, 1'b0, '0},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd1,    1'b0, '0},
      '{CMD_CENTER,  12'd0,    12'd0,    MODE_SPEED,    16'd1,     24'd0,    1'b0, '0},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd2047, 1'b0, '0},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd4095, 1'b1,
        '{12'd0,    12'd0,    1'b1}},
      '{CMD_SET,     12'd77,   12'd77,   MODE_SPEED,    16'd0,     24'd0,    1'b1,
        '{12'd77,   12'd77,   1'b0}},
      // Speed mode with no distance to cover gives a zero duration.
      '{CMD_MOVE,    12'd77,   12'd77,   MODE_SPEED,    16'd5,     24'd0,    1'b1,
        '{12'd77,   12'd77,   1'b1}},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd9,    1'b1,
        '{12'd77,   12'd77,   1'b1}},
      // Unknown commands leave the state alone.
      '{CMD_SPARE_HI, 12'd4095, 12'd4095, MODE_DURATION, 16'hFFFF, ELAPSED_MAX, 1'b1,
        '{12'd77,   12'd77,   1'b1}},
      '{CMD_SPARE_LO, 12'd1,   12'd2,    MODE_SPEED,    16'd3,     24'd4,    1'b1,
        '{12'd77,   12'd77,   1'b1}},
      '{CMD_MOVE,    12'd123,  12'd456,  MODE_DURATION, 16'd0,     24'd0,    1'b1,
        '{12'd123,  12'd456,  1'b1}},
      '{CMD_MOVE,    12'd4095, 12'd4095, MODE_DURATION, 16'hFFFF,  24'd0,    1'b1,
        '{12'd123,  12'd456,  1'b0}},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd32767, 1'b0, '0},
      '{CMD_TICK,    12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd65535, 1'b1,
        '{12'd4095, 12'd4095, 1'b1}},
      '{CMD_CAPTURE, 12'd0,    12'd0,    MODE_SPEED,    16'd0,     24'd0,    1'b1,
        '{12'd4095, 12'd4095, 1'b1}}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i])
      issue_request(plan[i].cmd, plan[i].tx, plan[i].ty, plan[i].mode, plan[i].val,
                    plan[i].el, plan[i].pin, plan[i].want);
    // Hold the sender until the block has answered everything so far.
    drain_results();

    while (n_sent < ITEMS) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        run_trajectory();
      else if (pick < 70)
        send_random(CMD_SET, 12'($urandom), 12'($urandom), 1'($urandom), 16'($urandom),
                    24'($urandom));
      else if (pick < 75)
        send_random(CMD_CAPTURE, 12'($urandom), 12'($urandom), 1'($urandom), 16'($urandom),
                    24'($urandom));
      else if (pick < 80)
        send_random(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 12'($urandom),
                    12'($urandom), 1'($urandom), 16'($urandom), 24'($urandom));
      else if (pick < 90)
        send_random(CMD_TICK, 12'($urandom), 12'($urandom), 1'($urandom), 16'($urandom),
                    24'($urandom));
      else
        send_random(($urandom_range(0, 3) == 0) ? CMD_CENTER : CMD_MOVE, 12'($urandom),
                    12'($urandom), 1'($urandom), 16'd0, 24'($urandom));
      if ($urandom_range(0, 99) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Sent %0d requests (%0d moves, %0d ticks) and checked %0d results.",
             n_sent, n_moves, n_ticks, n_checked);
    $display("Covered immediate, speed and duration moves, clamped ticks and center capture.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             CYCLE_LIMIT, pending_pos.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
